// ===== rtl/core/chcs_pkg.sv =====
// ----------------------------------------------------------------------------
// chcs_pkg: shared types and constants for the cubic Hermite curve sampler
// Widths of the fixed-point datapath, sequencer step codes and the
// round-and-saturate helper used on the way out.
// ----------------------------------------------------------------------------
package chcs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_W    = 16;
   localparam int FRAC_BITS  = 16;
   localparam int COUNT_W    = 7;
   localparam int OUT_W      = 18;

   // shared multiplier: weight (signed Q3.F) times coordinate or tangent
   localparam int MUL_A_W = FRAC_BITS + 4;
   localparam int MUL_B_W = COORD_W + 2;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int DIV_CNT_W = $clog2(FRAC_BITS);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EVAL   = 3'b100
   } state_type;

   // evaluation phases inside ST_EVAL
   typedef logic [3:0] phase_type;
   localparam phase_type PH_SQUARE   = 4'd0;
   localparam phase_type PH_TT       = 4'd1;
   localparam phase_type PH_CUBE     = 4'd2;
   localparam phase_type PH_TTT      = 4'd3;
   localparam phase_type PH_WEIGHT   = 4'd4;
   localparam phase_type PH_MAC_FIRST = 4'd5;
   localparam phase_type PH_MAC_LAST = 4'd12;
   localparam phase_type PH_ACC_FIRST = 4'd6;
   localparam phase_type PH_ACC_LAST = 4'd13;
   localparam phase_type PH_EMIT     = 4'd14;

   // round to nearest (ties up) and clamp to the output range
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sum;
      logic signed [ACC_W-1:0] r;
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      sum = acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
      r   = sum >>> FRAC_BITS;
      hi  = (ACC_W'(1) <<< (OUT_W - 1)) - ACC_W'(1);
      lo  = -(ACC_W'(1) <<< (OUT_W - 1));
      if (r > hi) begin
         round_sat = hi[OUT_W-1:0];
      end else if (r < lo) begin
         round_sat = lo[OUT_W-1:0];
      end else begin
         round_sat = r[OUT_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/cubic_hermite_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// cubic_hermite_curve_sampler: sampled cubic Hermite curve generator
// Takes four 2-D control points and a point count, emits that many points
// of the Hermite curve from the first to the fourth control point.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready channel carrying one request transaction: four
//   control points and point_count N. N of zero is accepted and dropped;
//   N above 64 is clamped to 64.
//   rsp_* is a valid/ready channel; each transaction is one curve point,
//   rsp_last_point marks the final point of a request.
// Sequence:
//   Each point runs a radix-2 restoring divider that forms the 16 bits of
//   t = i*2^16/N, then 15 steps that run one shared 20x18 multiplier for
//   t^2, t^3 and the eight weight-times-coordinate products.
//   req_ready is high only between requests.
// Stall:
//   A finished point sits in the output register. If the next point is ready
//   before the receiver has taken it, the sequencer holds at its final step.
//   The last point of a request may still wait while the next request is
//   accepted.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
module cubic_hermite_curve_sampler
   import chcs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_start_x,
   input  logic signed [COORD_W-1:0]  req_start_y,
   input  logic signed [COORD_W-1:0]  req_second_x,
   input  logic signed [COORD_W-1:0]  req_second_y,
   input  logic signed [COORD_W-1:0]  req_third_x,
   input  logic signed [COORD_W-1:0]  req_third_y,
   input  logic signed [COORD_W-1:0]  req_end_x,
   input  logic signed [COORD_W-1:0]  req_end_y,
   input  logic [COUNT_W-1:0]         req_point_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_W-1:0]    rsp_curve_x,
   output logic signed [OUT_W-1:0]    rsp_curve_y,
   output logic                       rsp_last_point
);

   localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_POINTS);

   // control registers
   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     index_ff, index_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [COUNT_W-1:0]               rem_ff, rem_in;
   logic [FRAC_BITS-1:0]             t_ff, t_in;
   logic [FRAC_BITS-1:0]             tt_ff, tt_in;
   logic [FRAC_BITS-1:0]             ttt_ff, ttt_in;
   logic signed [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [ACC_W-1:0]          acc_x_ff, acc_x_in;
   logic signed [ACC_W-1:0]          acc_y_ff, acc_y_in;
   logic signed [MUL_A_W-1:0]        weight_ff [4];
   logic signed [MUL_A_W-1:0]        weight_in [4];
   logic signed [MUL_B_W-1:0]        coef_ff [8];
   logic signed [MUL_B_W-1:0]        coef_in [8];
   logic signed [OUT_W-1:0]          curve_x_ff, curve_x_in;
   logic signed [OUT_W-1:0]          curve_y_ff, curve_y_in;
   logic                             last_ff, last_in;

   // combinational helpers
   logic                        req_fire;
   logic                        out_free;
   logic                        is_last;
   logic [COUNT_W:0]            rem_dbl;
   logic [2*FRAC_BITS-1:0]      prod_rnd;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_A_W-1:0]   t_s, tt_s, ttt_s, one_s;
   logic [2:0]                  mac_sel;
   logic [2:0]                  acc_sel;
   logic [COUNT_W-1:0]          count_sat;

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign is_last        = (index_ff == count_ff - COUNT_W'(1));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_curve_x    = curve_x_ff;
   assign rsp_curve_y    = curve_y_ff;
   assign rsp_last_point = last_ff;

   assign count_sat = (req_point_count > MAX_N) ? MAX_N : req_point_count;
   assign rem_dbl   = {rem_ff, 1'b0};
   assign prod_rnd  = prod_ff[2*FRAC_BITS-1:0] + (2*FRAC_BITS)'(1 << (FRAC_BITS - 1));
   assign mac_sel   = 3'(phase_ff - PH_MAC_FIRST);
   assign acc_sel   = 3'(phase_ff - PH_ACC_FIRST);

   // Q0.F powers of t widened to the signed weight format
   assign t_s   = signed'({{(MUL_A_W-FRAC_BITS){1'b0}}, t_ff});
   assign tt_s  = signed'({{(MUL_A_W-FRAC_BITS){1'b0}}, tt_ff});
   assign ttt_s = signed'({{(MUL_A_W-FRAC_BITS){1'b0}}, ttt_ff});
   assign one_s = MUL_A_W'(1) <<< FRAC_BITS;

   // select shared multiplier operands for the current phase
   always_comb begin
      mul_a = t_s;
      mul_b = signed'({{(MUL_B_W-FRAC_BITS){1'b0}}, t_ff});
      case (phase_ff) inside
         PH_CUBE: begin
            mul_a = tt_s;
         end
         [PH_MAC_FIRST:PH_MAC_LAST]: begin
            mul_a = weight_ff[mac_sel[1:0]];
            mul_b = coef_ff[mac_sel];
         end
         default: begin
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      div_cnt_in   = div_cnt_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      rem_in       = rem_ff;
      t_in         = t_ff;
      tt_in        = tt_ff;
      ttt_in       = ttt_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      weight_in    = weight_ff;
      coef_in      = coef_ff;
      curve_x_in   = curve_x_ff;
      curve_y_in   = curve_y_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            // latch a request; drop one that asks for no points
            if (req_fire && (req_point_count != '0)) begin
               count_in   = count_sat;
               index_in   = '0;
               rem_in     = '0;
               div_cnt_in = '0;
               coef_in[0] = MUL_B_W'(req_start_x);
               coef_in[1] = MUL_B_W'(req_second_x) - MUL_B_W'(req_start_x);
               coef_in[2] = MUL_B_W'(req_third_x) - MUL_B_W'(req_end_x);
               coef_in[3] = MUL_B_W'(req_end_x);
               coef_in[4] = MUL_B_W'(req_start_y);
               coef_in[5] = MUL_B_W'(req_second_y) - MUL_B_W'(req_start_y);
               coef_in[6] = MUL_B_W'(req_third_y) - MUL_B_W'(req_end_y);
               coef_in[7] = MUL_B_W'(req_end_y);
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // one quotient bit of index * 2^F / count per cycle
            if (rem_dbl >= {1'b0, count_ff}) begin
               rem_in = COUNT_W'(rem_dbl - {1'b0, count_ff});
               t_in   = {t_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_dbl[COUNT_W-1:0];
               t_in   = {t_ff[FRAC_BITS-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(FRAC_BITS - 1)) begin
               phase_in = PH_SQUARE;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            phase_in = phase_ff + phase_type'(1);
            case (phase_ff) inside
               PH_TT: begin
                  tt_in = prod_rnd[2*FRAC_BITS-1:FRAC_BITS];
               end
               PH_TTT: begin
                  ttt_in = prod_rnd[2*FRAC_BITS-1:FRAC_BITS];
               end
               PH_WEIGHT: begin
                  // Hermite basis in signed Q3.F
                  weight_in[0] = (ttt_s <<< 1) - (tt_s <<< 1) - tt_s + one_s;
                  weight_in[1] = ttt_s - (tt_s <<< 1) + t_s;
                  weight_in[2] = ttt_s - tt_s;
                  weight_in[3] = (tt_s <<< 1) + tt_s - (ttt_s <<< 1);
                  acc_x_in     = '0;
                  acc_y_in     = '0;
               end
               PH_EMIT: begin
                  // hold here until the output register frees up
                  phase_in = phase_ff;
                  if (out_free) begin
                     curve_x_in   = round_sat(acc_x_ff);
                     curve_y_in   = round_sat(acc_y_ff);
                     last_in      = is_last;
                     rsp_valid_in = 1'b1;
                     rem_in       = index_ff + COUNT_W'(1);
                     index_in     = index_ff + COUNT_W'(1);
                     div_cnt_in   = '0;
                     state_in     = is_last ? ST_IDLE : ST_DIVIDE;
                  end
               end
               default: begin
               end
            endcase
            // fold the previous product into the x or y sum
            if ((phase_ff >= PH_ACC_FIRST) && (phase_ff <= PH_ACC_LAST)) begin
               if (acc_sel[2]) begin
                  acc_y_in = acc_y_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
               end else begin
                  acc_x_in = acc_x_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SQUARE;
         div_cnt_ff   <= '0;
         count_ff     <= '0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         div_cnt_ff   <= div_cnt_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      t_ff       <= t_in;
      tt_ff      <= tt_in;
      ttt_ff     <= ttt_in;
      prod_ff    <= prod_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      weight_ff  <= weight_in;
      coef_ff    <= coef_in;
      curve_x_ff <= curve_x_in;
      curve_y_ff <= curve_y_in;
      last_ff    <= last_in;
   end

endmodule

// ===== rtl/core/chcs_checker.sv =====
// ----------------------------------------------------------------------------
// chcs_checker: port-level checks for the cubic Hermite curve sampler
// Watches the request and response channels over time; bound to the top.
// ----------------------------------------------------------------------------
module chcs_checker
   import chcs_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [COUNT_W-1:0]       req_point_count,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [OUT_W-1:0]  rsp_curve_x,
   input logic signed [OUT_W-1:0]  rsp_curve_y,
   input logic                     rsp_last_point
);

   // hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_curve_x)
         && $stable(rsp_curve_y) && $stable(rsp_last_point))
      else $error("stalled response changed");

   // a request with points keeps the block busy afterwards
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_point_count != '0) |=> !req_ready)
      else $error("ready right after a non-empty request");

   // an empty request leaves the block idle
   a_empty_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_point_count == '0) |=> req_ready)
      else $error("empty request made the block busy");

   // a new response only comes out of an active request
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while idle");

endmodule

bind cubic_hermite_curve_sampler chcs_checker u_chcs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_point_count (req_point_count),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_curve_x     (rsp_curve_x),
   .rsp_curve_y     (rsp_curve_y),
   .rsp_last_point  (rsp_last_point)
);

// ===== tb/sv/cubic_hermite_curve_sampler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_hermite_curve_sampler_test: self-checking bench for the curve sampler
// Sends control-point requests, computes every expected curve point in the
// bench and compares each response transaction field by field, under
// directed corners, random traffic, random idling and long output stalls.
// ----------------------------------------------------------------------------
module cubic_hermite_curve_sampler_test;
   import chcs_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic signed [COORD_W-1:0] third_x;
      logic signed [COORD_W-1:0] third_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [COUNT_W-1:0]        point_count;
   } curve_request_type;

   typedef struct {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic                    last;
   } curve_point_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_start_x = '0;
   logic signed [COORD_W-1:0] req_start_y = '0;
   logic signed [COORD_W-1:0] req_second_x = '0;
   logic signed [COORD_W-1:0] req_second_y = '0;
   logic signed [COORD_W-1:0] req_third_x = '0;
   logic signed [COORD_W-1:0] req_third_y = '0;
   logic signed [COORD_W-1:0] req_end_x = '0;
   logic signed [COORD_W-1:0] req_end_y = '0;
   logic [COUNT_W-1:0]        req_point_count = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]   rsp_curve_x;
   logic signed [OUT_W-1:0]   rsp_curve_y;
   logic                      rsp_last_point;

   curve_point_type pending_points[$];
   int              mismatch_count = 0;
   int              points_seen = 0;
   int              sender_idle_pct = 0;
   int              receiver_stall_pct = 0;
   int              hold_left = 0;

   cubic_hermite_curve_sampler DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_second_x   (req_second_x),
      .req_second_y   (req_second_y),
      .req_third_x    (req_third_x),
      .req_third_y    (req_third_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_point_count(req_point_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_curve_x    (rsp_curve_x),
      .rsp_curve_y    (rsp_curve_y),
      .rsp_last_point (rsp_last_point)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round to nearest with ties up, then clamp to the output range
   function automatic logic signed [OUT_W-1:0] round_clamp(input longint acc);
      longint r;
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (OUT_W - 1)) - 1;
      lo = -(longint'(1) <<< (OUT_W - 1));
      r  = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return OUT_W'(r);
   endfunction

   // expand one request into its sampled Hermite points
   function automatic void queue_curve_points(input curve_request_type r);
      longint          unit;
      longint          half;
      longint          n;
      longint          t;
      longint          tt;
      longint          ttt;
      longint          h00;
      longint          h10;
      longint          h01;
      longint          h11;
      longint          p1x;
      longint          p1y;
      longint          p4x;
      longint          p4y;
      longint          tan1x;
      longint          tan1y;
      longint          tan2x;
      longint          tan2y;
      curve_point_type pt;
      unit = longint'(1) <<< FRAC_BITS;
      half = unit >>> 1;
      n = longint'(r.point_count);
      if (n == 0) return;
      if (n > MAX_POINTS) n = MAX_POINTS;
      p1x = longint'(r.start_x);
      p1y = longint'(r.start_y);
      p4x = longint'(r.end_x);
      p4y = longint'(r.end_y);
      tan1x = longint'(r.second_x) - p1x;
      tan1y = longint'(r.second_y) - p1y;
      // end tangent points from the fourth control point to the third
      tan2x = longint'(r.third_x) - p4x;
      tan2y = longint'(r.third_y) - p4y;
      for (longint i = 0; i < n; i++) begin
         t   = (i * unit) / n;
         tt  = (t * t + half) >>> FRAC_BITS;
         ttt = (tt * t + half) >>> FRAC_BITS;
         h00 = 2 * ttt - 3 * tt + unit;
         h10 = ttt - 2 * tt + t;
         h01 = ttt - tt;
         h11 = -2 * ttt + 3 * tt;
         pt.x = round_clamp(h00 * p1x + h10 * tan1x + h01 * tan2x + h11 * p4x);
         pt.y = round_clamp(h00 * p1y + h10 * tan1y + h01 * tan2y + h11 * p4y);
         pt.last = (i == n - 1);
         pending_points.push_back(pt);
      end
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("ERROR: point %0d: %s", points_seen, what);
   endfunction

   // coordinates and count are truncated to their field widths
   function automatic curve_request_type make_request(
      input int sx, sy, ax, ay, bx, by, ex, ey,
      input int n);
      curve_request_type r;
      r.start_x = COORD_W'(sx);
      r.start_y = COORD_W'(sy);
      r.second_x = COORD_W'(ax);
      r.second_y = COORD_W'(ay);
      r.third_x = COORD_W'(bx);
      r.third_y = COORD_W'(by);
      r.end_x = COORD_W'(ex);
      r.end_y = COORD_W'(ey);
      r.point_count = COUNT_W'(n);
      return r;
   endfunction

   // mostly full-range coordinates, some pinned to the extremes, zero or -1
   function automatic int random_coord();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 4) return -(1 << (COORD_W - 1));
      if (sel < 8) return (1 << (COORD_W - 1)) - 1;
      if (sel < 10) return 0;
      if (sel < 12) return -1;
      return int'($urandom_range((1 << COORD_W) - 1));
   endfunction

   // keep most counts small so long requests stay rare
   function automatic curve_request_type random_request();
      int unsigned sel;
      int unsigned n;
      sel = $urandom_range(99);
      if (sel < 4) n = 0;
      else if (sel < 80) n = $urandom_range(8, 1);
      else if (sel < 92) n = $urandom_range(MAX_POINTS - 1, 9);
      else if (sel < 96) n = MAX_POINTS;
      else n = $urandom_range((1 << COUNT_W) - 1, MAX_POINTS + 1);
      return make_request(random_coord(), random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(), random_coord(),
                          int'(n));
   endfunction

   // offer one request transaction and predict its points on acceptance
   task automatic send_request(input curve_request_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_x <= r.start_x;
      req_start_y <= r.start_y;
      req_second_x <= r.second_x;
      req_second_y <= r.second_y;
      req_third_x <= r.third_x;
      req_third_y <= r.third_y;
      req_end_x <= r.end_x;
      req_end_y <= r.end_y;
      req_point_count <= r.point_count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queue_curve_points(r);
   endtask

   // drop valid and hold off until every expected point has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic test_corner_points();
      int hi;
      int lo;
      hi = (1 << (COORD_W - 1)) - 1;
      lo = -(1 << (COORD_W - 1));
      send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 1));
      send_request(make_request(100, -200, 300, -400, 500, -600, 700, -800, 1));
      send_request(make_request(100, -200, 300, -400, 500, -600, 700, -800, 2));
      send_request(make_request(-1, 1, -1, 1, 1, -1, 1, -1, 3));
      send_request(make_request(hi, hi, hi, hi, hi, hi, hi, hi, 8));
      send_request(make_request(lo, lo, lo, lo, lo, lo, lo, lo, 8));
      // widest tangents of both signs
      send_request(make_request(lo, hi, hi, lo, lo, hi, hi, lo, 16));
      send_request(make_request(hi, lo, lo, hi, hi, lo, lo, hi, 16));
      send_request(make_request(hi, lo, lo, hi, lo, hi, hi, lo, 7));
      send_request(make_request(12345, -23456, -321, 4321, 30000, -30000, -5, 5,
                                MAX_POINTS));
      wait_drained();
   endtask

   task automatic test_zero_count();
      send_request(make_request(1000, 2000, 3000, 4000, 5000, 6000, 7000, 8000, 4));
      wait_drained();
      // a zero count is taken and dropped with no points
      send_request(make_request(-1, -1, -1, -1, -1, -1, -1, -1, 0));
      send_request(make_request(11, 22, 33, 44, 55, 66, 77, 88, 5));
      send_request(make_request(9, 9, 9, 9, 9, 9, 9, 9, 0));
      send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   task automatic test_count_clamp();
      send_request(make_request(-500, 500, 2500, -2500, -7000, 7000, 900, -900,
                                MAX_POINTS + 1));
      send_request(make_request(32000, -32000, -32000, 32000, 1, 2, 3, 4,
                                (1 << COUNT_W) - 1));
      send_request(make_request(7, -7, 70, -70, 700, -700, 7000, -7000, 'h40));
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      @(negedge clock);
      hold_left = 600;
      @(posedge clock);
      // keep offering while the receiver is held off so the input stalls
      for (int k = 0; k < 6; k++) begin
         curve_request_type r;
         r = random_request();
         r.point_count = COUNT_W'($urandom_range(4, 2));
         send_request(r);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int sender_pcts[4];
      int receiver_pcts[4];
      sender_pcts = '{0, 75, 0, 16};
      receiver_pcts = '{0, 0, 75, 16};
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = sender_pcts[phase];
         receiver_stall_pct = receiver_pcts[phase];
         for (int k = 0; k < 82; k++) send_request(random_request());
         wait_drained();
      end
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   // drive response ready: long hold-off first, then random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // compare each accepted response transaction with the oldest prediction
   always @(posedge clock) begin : point_checker
      curve_point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            note_mismatch($sformatf("unexpected point x %0d y %0d last %0b",
                                    rsp_curve_x, rsp_curve_y, rsp_last_point));
         end else begin
            want = pending_points.pop_front();
            if (rsp_curve_x !== want.x)
               note_mismatch($sformatf("curve_x expected %0d got %0d", want.x, rsp_curve_x));
            if (rsp_curve_y !== want.y)
               note_mismatch($sformatf("curve_y expected %0d got %0d", want.y, rsp_curve_y));
            if (rsp_last_point !== want.last)
               note_mismatch($sformatf("last_point expected %0b got %0b",
                                       want.last, rsp_last_point));
         end
         points_seen++;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_points();
      test_zero_count();
      test_count_clamp();
      test_output_backpressure();
      test_random_traffic();
      wait_drained();
      // let any stray point surface
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #50_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
